### rtl/core/lars_pkg.sv
`default_nettype none

package lars_pkg;

  localparam int ROW_BITS = 64;
  localparam int COLS_BITS = 7;
  localparam int ROW_NUM_BITS = 10;
  localparam int ROW_NUM_TOP = 1023;
  localparam int DEF_GRID_COLUMNS = 64;
  localparam int DEF_MAX_ROWS = 1024;
  localparam logic [COLS_BITS-1:0] COLUMNS_RESET = 7'd64;

  typedef logic [ROW_BITS-1:0] row_t;
  typedef logic [ROW_NUM_BITS-1:0] row_num_t;

  // One pending evolution: three rows, the index of the emitted row and its end flag.
  typedef struct packed {
    logic     valid;
    row_t     above;
    row_t     here;
    row_t     below;
    row_num_t row_number;
    logic     done;
  } job_t;

  // Cells at or above the active width, capped at the grid width, read as dead.
  function automatic row_t valid_mask(input logic [COLS_BITS-1:0] cols,
                                      input int grid_columns);
    int   n;
    row_t m;
    n = (int'(cols) > grid_columns) ? grid_columns : int'(cols);
    for (int k = 0; k < ROW_BITS; k++) begin
      m[k] = (k < n);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

### rtl/core/lars_if.sv
`default_nettype none

interface lars_in_if;
  logic                      valid;
  logic                      ready;
  logic [lars_pkg::ROW_BITS-1:0] row_cells;
  logic                      last_row;

  modport source (output valid, output row_cells, output last_row, input ready);
  modport sink (input valid, input row_cells, input last_row, output ready);
endinterface

interface lars_out_if;
  logic                          valid;
  logic                          ready;
  logic [lars_pkg::ROW_BITS-1:0]     next_cells;
  logic [lars_pkg::ROW_NUM_BITS-1:0] row_number;
  logic                          frame_done;

  modport source (output valid, output next_cells, output row_number, output frame_done,
                  input ready);
  modport sink (input valid, input next_cells, input row_number, input frame_done,
                output ready);
endinterface

`default_nettype wire

### rtl/core/lars_frame_ctrl.sv
`default_nettype none

module lars_frame_ctrl #(
  parameter int MAX_ROWS = lars_pkg::DEF_MAX_ROWS
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire lars_pkg::row_t  mask,
  input  wire logic            in_valid,
  output      logic            in_ready,
  input  wire lars_pkg::row_t  in_cells,
  input  wire logic            in_last,
  input  wire logic            take,
  output lars_pkg::job_t       job
);

  localparam int CNT_W = $clog2(MAX_ROWS + 1);

  lars_pkg::row_t     upper_row;
  lars_pkg::row_t     middle_row;
  logic [CNT_W-1:0]   rows_received;

  lars_pkg::row_t     st_upper;
  lars_pkg::row_t     st_middle;
  lars_pkg::row_t     st_lower;
  lars_pkg::row_num_t st_num_a;
  lars_pkg::row_num_t st_num_b;
  logic               has_a;
  logic               has_b;

  logic               accept;
  logic               first_row;
  lars_pkg::row_t     row_masked;
  lars_pkg::row_num_t num_prev;
  lars_pkg::row_num_t num_here;
  logic [CNT_W-1:0]   rows_minus_one;

  assign accept     = in_valid && in_ready;
  assign first_row  = (rows_received == '0);
  assign row_masked = in_cells & mask;
  assign rows_minus_one = rows_received - CNT_W'(1);

  assign num_here = (32'(rows_received) > 32'(lars_pkg::ROW_NUM_TOP)) ?
                    lars_pkg::ROW_NUM_BITS'(lars_pkg::ROW_NUM_TOP) :
                    lars_pkg::ROW_NUM_BITS'(rows_received);
  assign num_prev = (32'(rows_minus_one) > 32'(lars_pkg::ROW_NUM_TOP)) ?
                    lars_pkg::ROW_NUM_BITS'(lars_pkg::ROW_NUM_TOP) :
                    lars_pkg::ROW_NUM_BITS'(rows_minus_one);

  // The stage frees up when it is empty or its only remaining job leaves this cycle.
  assign in_ready = !(has_a || has_b) || (take && !(has_a && has_b));

  always_comb begin
    job.valid = has_a || has_b;
    if (has_a) begin
      job.above      = st_upper;
      job.here       = st_middle;
      job.below      = st_lower;
      job.row_number = st_num_a;
      job.done       = 1'b0;
    end else begin
      job.above      = st_middle;
      job.here       = st_lower;
      job.below      = '0;
      job.row_number = st_num_b;
      job.done       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_row     <= '0;
      middle_row    <= '0;
      rows_received <= '0;
      has_a         <= 1'b0;
      has_b         <= 1'b0;
    end else begin
      if (take && (has_a || has_b)) begin
        if (has_a) begin
          has_a <= 1'b0;
        end else begin
          has_b <= 1'b0;
        end
      end
      if (accept) begin
        if (first_row) begin
          st_middle <= '0;
          st_lower  <= row_masked;
          st_num_b  <= '0;
          has_a     <= 1'b0;
          has_b     <= in_last;
          upper_row <= '0;
          if (in_last) begin
            middle_row    <= '0;
            rows_received <= '0;
          end else begin
            middle_row    <= row_masked;
            rows_received <= CNT_W'(1);
          end
        end else begin
          st_upper  <= upper_row;
          st_middle <= middle_row;
          st_lower  <= row_masked;
          st_num_a  <= num_prev;
          st_num_b  <= num_here;
          has_a     <= 1'b1;
          has_b     <= in_last;
          if (in_last) begin
            upper_row     <= '0;
            middle_row    <= '0;
            rows_received <= '0;
          end else begin
            upper_row  <= middle_row;
            middle_row <= row_masked;
            if (32'(rows_received) < MAX_ROWS) begin
              rows_received <= rows_received + CNT_W'(1);
            end
          end
        end
      end
    end
  end

  a_last_queues_own_row: assert property (@(posedge clk) disable iff (rst)
    accept && in_last |=> has_b)
    else $error("bottom row did not queue its own result");

  a_frame_advances: assert property (@(posedge clk) disable iff (rst)
    accept && !in_last |=> rows_received != '0)
    else $error("row count failed to advance within a frame");

  a_pair_in_order: assert property (@(posedge clk) disable iff (rst)
    take && has_a && has_b |=> has_b && !has_a)
    else $error("second result of the bottom row was lost or reordered");

endmodule

`default_nettype wire

### rtl/core/lars_evolve.sv
`default_nettype none

module lars_evolve (
  input  wire lars_pkg::row_t above,
  input  wire lars_pkg::row_t here,
  input  wire lars_pkg::row_t below,
  input  wire lars_pkg::row_t mask,
  output lars_pkg::row_t      cells
);

  localparam int W = lars_pkg::ROW_BITS;

  logic [W+1:0] pad_a;
  logic [W+1:0] pad_h;
  logic [W+1:0] pad_b;

  // Dead cells pad both edges so every column sees a full neighbourhood.
  assign pad_a = {1'b0, above & mask, 1'b0};
  assign pad_h = {1'b0, here & mask, 1'b0};
  assign pad_b = {1'b0, below & mask, 1'b0};

  for (genvar k = 0; k < W; k++) begin : g_col
    logic [3:0] count;
    assign count = 4'(pad_a[k]) + 4'(pad_a[k+1]) + 4'(pad_a[k+2])
                 + 4'(pad_h[k])                  + 4'(pad_h[k+2])
                 + 4'(pad_b[k]) + 4'(pad_b[k+1]) + 4'(pad_b[k+2]);
    assign cells[k] = mask[k] && ((count == 4'd3) || (pad_h[k+1] && count == 4'd2));
  end

endmodule

`default_nettype wire

### rtl/core/lars_result_reg.sv
`default_nettype none

module lars_result_reg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire lars_pkg::job_t job,
  input  wire lars_pkg::row_t cells,
  output      logic           take,
  lars_out_if.source          row_out
);

  assign take = job.valid && (!row_out.valid || row_out.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_out.valid <= 1'b0;
    end else if (take) begin
      row_out.valid <= 1'b1;
    end else if (row_out.ready) begin
      row_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      row_out.next_cells <= cells;
      row_out.row_number <= job.row_number;
      row_out.frame_done <= job.done;
    end
  end

  a_done_reaches_port: assert property (@(posedge clk) disable iff (rst)
    take && job.done |=> row_out.valid && row_out.frame_done)
    else $error("frame end flag did not reach the result register");

endmodule

`default_nettype wire

### rtl/core/life_automaton_row_step.sv
// An accepted row waits in the frame control stage, its result in the result
// register. One row per cycle unless the output stalls; the bottom row of a
// frame gives two words and holds the input, set by the single evolution unit.
// Reset clears the stored rows and row count and sets the active width to 64.
`default_nettype none

module life_automaton_row_step #(
  parameter int GRID_COLUMNS = lars_pkg::DEF_GRID_COLUMNS,
  parameter int MAX_ROWS     = lars_pkg::DEF_MAX_ROWS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write_en,
  input  wire logic [lars_pkg::COLS_BITS-1:0]  cfg_write_data,
  lars_in_if.sink                              row_in,
  lars_out_if.source                           row_out
);

  logic [lars_pkg::COLS_BITS-1:0] columns_in_use;
  lars_pkg::row_t                 mask;
  lars_pkg::job_t                 job;
  lars_pkg::row_t                 cells;
  logic                           take;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns_in_use <= lars_pkg::COLUMNS_RESET;
    end else if (cfg_write_en) begin
      columns_in_use <= cfg_write_data;
    end
  end

  assign mask = lars_pkg::valid_mask(columns_in_use, GRID_COLUMNS);

  lars_frame_ctrl #(
    .MAX_ROWS (MAX_ROWS)
  ) u_frame_ctrl (
    .clk      (clk),
    .rst      (rst),
    .mask     (mask),
    .in_valid (row_in.valid),
    .in_ready (row_in.ready),
    .in_cells (row_in.row_cells),
    .in_last  (row_in.last_row),
    .take     (take),
    .job      (job)
  );

  lars_evolve u_evolve (
    .above (job.above),
    .here  (job.here),
    .below (job.below),
    .mask  (mask),
    .cells (cells)
  );

  lars_result_reg u_result_reg (
    .clk     (clk),
    .rst     (rst),
    .job     (job),
    .cells   (cells),
    .take    (take),
    .row_out (row_out)
  );

endmodule

`default_nettype wire

### test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_COLS = 64;
  localparam int FRAME_ROW_CAP = 1024;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SEGMENT_ROWS = 5;
  localparam int SEGMENTS = 11;

  typedef struct packed {
    lars_pkg::row_t cells;
    logic           last;
    logic           drain;
  } grid_row_t;

  typedef struct packed {
    lars_pkg::row_t     cells;
    lars_pkg::row_num_t number;
    logic               done;
  } life_word_t;

  logic clk;
  logic rst;
  logic cfg_write_en;
  logic [lars_pkg::COLS_BITS-1:0] cfg_write_data;

  lars_in_if row_in ();
  lars_out_if row_out ();

  life_automaton_row_step dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .row_in         (row_in),
    .row_out        (row_out)
  );

  grid_row_t  pending_rows[$];
  life_word_t expected_words[$];

  logic [lars_pkg::COLS_BITS-1:0] active_columns;
  lars_pkg::row_t grid_above;
  lars_pkg::row_t grid_here;
  int   frame_rows;

  bit calm;
  int send_gap;
  int recv_stall;
  int cycle_count;
  int failures;
  int rows_accepted;
  int words_checked;
  int frames_queued;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic lars_pkg::row_t column_mask(input logic [lars_pkg::COLS_BITS-1:0] cols);
    int n;
    n = (int'(cols) > GRID_COLS) ? GRID_COLS : int'(cols);
    if (n >= lars_pkg::ROW_BITS) return '1;
    return (lars_pkg::row_t'(1) << n) - lars_pkg::row_t'(1);
  endfunction

  // Next state of the middle row, with dead cells beyond both edges.
  function automatic lars_pkg::row_t next_generation(input lars_pkg::row_t above,
                                                     input lars_pkg::row_t here,
                                                     input lars_pkg::row_t below,
                                                     input lars_pkg::row_t mask);
    lars_pkg::row_t a;
    lars_pkg::row_t h;
    lars_pkg::row_t b;
    lars_pkg::row_t nxt;
    int   live;
    a = above & mask;
    h = here & mask;
    b = below & mask;
    nxt = '0;
    for (int k = 0; k < lars_pkg::ROW_BITS; k++) begin
      live = int'(a[k]) + int'(b[k]);
      if (k > 0) live += int'(a[k-1]) + int'(h[k-1]) + int'(b[k-1]);
      if (k < lars_pkg::ROW_BITS - 1) live += int'(a[k+1]) + int'(h[k+1]) + int'(b[k+1]);
      nxt[k] = (live == 3) || (h[k] && live == 2);
    end
    return nxt & mask;
  endfunction

  function automatic void expect_word(input lars_pkg::row_t cells, input int number,
                                      input logic done);
    life_word_t w;
    w.cells = cells;
    w.number = (number > lars_pkg::ROW_NUM_TOP) ?
               lars_pkg::row_num_t'(lars_pkg::ROW_NUM_TOP) : lars_pkg::row_num_t'(number);
    w.done = done;
    expected_words.push_back(w);
  endfunction

  function automatic void take_row(input lars_pkg::row_t cells, input logic last);
    lars_pkg::row_t mask;
    lars_pkg::row_t row;
    mask = column_mask(active_columns);
    row = cells & mask;
    if (frame_rows == 0) begin
      if (last) begin
        expect_word(next_generation('0, row, '0, mask), 0, 1'b1);
      end else begin
        grid_above = '0;
        grid_here = row;
        frame_rows = 1;
      end
    end else begin
      expect_word(next_generation(grid_above, grid_here, row, mask), frame_rows - 1, 1'b0);
      grid_above = grid_here;
      grid_here = row;
      if (last) begin
        expect_word(next_generation(grid_above, grid_here, '0, mask), frame_rows, 1'b1);
        grid_above = '0;
        grid_here = '0;
        frame_rows = 0;
      end else if (frame_rows < FRAME_ROW_CAP) begin
        frame_rows++;
      end
    end
  endfunction

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin
    bit present;
    grid_row_t item;
    if (rst) begin
      row_in.valid <= 1'b0;
      send_gap = 0;
    end else begin
      present = row_in.valid;
      if (row_in.valid && row_in.ready) begin
        take_row(row_in.row_cells, row_in.last_row);
        rows_accepted++;
        present = 1'b0;
      end
      if (!present) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_rows.size() != 0 &&
                     !(pending_rows[0].drain && expected_words.size() != 0)) begin
          if (!calm && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 18);
          end else begin
            item = pending_rows.pop_front();
            row_in.row_cells <= item.cells;
            row_in.last_row <= item.last;
            present = 1'b1;
          end
        end
      end
      row_in.valid <= present;
    end
  end

  always @(posedge clk) begin
    life_word_t want;
    if (rst) begin
      row_out.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (row_out.valid && row_out.ready) begin
        if (expected_words.size() == 0) begin
          note_failure($sformatf("unexpected word cells=%h row=%0d done=%b",
                                 row_out.next_cells, row_out.row_number, row_out.frame_done));
        end else begin
          want = expected_words.pop_front();
          words_checked++;
          if (row_out.next_cells !== want.cells || row_out.row_number !== want.number ||
              row_out.frame_done !== want.done) begin
            note_failure($sformatf(
              "expected cells=%h row=%0d done=%b, got cells=%h row=%0d done=%b",
              want.cells, want.number, want.done,
              row_out.next_cells, row_out.row_number, row_out.frame_done));
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        row_out.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        recv_stall = $urandom_range(0, 18);
        row_out.ready <= 1'b0;
      end else begin
        row_out.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d words outstanding.",
               cycle_count, expected_words.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic lars_pkg::row_t random_cells();
    lars_pkg::row_t r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: r = r & {$urandom, $urandom} & {$urandom, $urandom};
      1: r = r | {$urandom, $urandom};
      2: r = r ^ (lars_pkg::row_t'(1) << $urandom_range(0, lars_pkg::ROW_BITS - 1));
      default: ;
    endcase
    return r;
  endfunction

  function automatic void push_row(input lars_pkg::row_t cells, input logic last,
                                   input logic drain);
    grid_row_t item;
    item.cells = cells;
    item.last = last;
    item.drain = drain;
    pending_rows.push_back(item);
    if (last) frames_queued++;
  endfunction

  function automatic void queue_frame(input int length);
    for (int i = 0; i < length; i++) begin
      push_row(random_cells(), i == length - 1, !calm && $urandom_range(0, 49) == 0);
    end
  endfunction

  function automatic int frame_length();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) return $urandom_range(1, 6);
    if (pick < 19) return $urandom_range(7, 20);
    return $urandom_range(21, 60);
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_rows.size() != 0 || row_in.valid || expected_words.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_columns(input int cols);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= lars_pkg::COLS_BITS'(cols);
    @(posedge clk);
    cfg_write_en <= 1'b0;
    active_columns = lars_pkg::COLS_BITS'(cols);
    @(negedge clk);
  endtask

  initial begin
    int widths[8];
    int queued;
    widths = '{64, 1, 2, 3, 127, 63, 65, 0};
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_write_data = '0;
    row_in.valid = 1'b0;
    row_in.row_cells = '0;
    row_in.last_row = 1'b0;
    row_out.ready = 1'b0;
    active_columns = lars_pkg::COLUMNS_RESET;
    grid_above = '0;
    grid_here = '0;
    frame_rows = 0;
    calm = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Single-row frames, a blinker, corner cells and checkerboards at full width.
    push_row('1, 1'b1, 1'b0);
    push_row('0, 1'b1, 1'b0);
    push_row('0, 1'b0, 1'b0);
    push_row(64'h38, 1'b0, 1'b0);
    push_row('0, 1'b1, 1'b0);
    push_row(64'h8000_0000_0000_0001, 1'b0, 1'b0);
    push_row(64'hC000_0000_0000_0003, 1'b0, 1'b0);
    push_row(64'h8000_0000_0000_0001, 1'b1, 1'b0);
    push_row('1, 1'b0, 1'b0);
    push_row('1, 1'b1, 1'b0);
    push_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0);
    push_row(64'h5555_5555_5555_5555, 1'b0, 1'b0);
    push_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0);
    wait_drained();
    set_columns(0);
    push_row('1, 1'b0, 1'b0);
    push_row('1, 1'b0, 1'b0);
    push_row(random_cells(), 1'b1, 1'b0);
    wait_drained();
    set_columns(127);
    push_row('1, 1'b0, 1'b0);
    push_row('1, 1'b1, 1'b0);
    wait_drained();
    set_columns(1);
    push_row('1, 1'b0, 1'b0);
    push_row('1, 1'b0, 1'b0);
    push_row('1, 1'b1, 1'b0);
    wait_drained();
    set_columns(63);
    push_row('1, 1'b0, 1'b0);
    push_row(64'h8000_0000_0000_0000, 1'b0, 1'b0);
    push_row('1, 1'b1, 1'b0);

    for (int s = 0; s < SEGMENTS; s++) begin
      wait_drained();
      if (s == SEGMENTS - 1) calm = 1'b1;
      set_columns(s < 8 ? widths[s] : $urandom_range(0, 127));
      queued = 0;
      while (queued < SEGMENT_ROWS) begin
        int len;
        len = frame_length();
        queue_frame(len);
        queued += len;
      end
      // A frame long enough to saturate the row count and the row number.
      if (s == 3) begin
        wait_drained();
        set_columns(64);
        queue_frame(FRAME_ROW_CAP + 6);
      end
    end

    wait_drained();
    repeat (10) @(negedge clk);
    if (expected_words.size() != 0) begin
      note_failure($sformatf("%0d expected words never arrived", expected_words.size()));
    end
    $display("Sent %0d rows in %0d frames and checked %0d words, at widths from 0 to 127.",
             rows_accepted, frames_queued, words_checked);
    $display("Random stalls on both sides, a saturated long frame; %0d mismatches.", failures);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### life_automaton_row_step.f
rtl/core/lars_pkg.sv
rtl/core/lars_if.sv
rtl/core/lars_frame_ctrl.sv
rtl/core/lars_evolve.sv
rtl/core/lars_result_reg.sv
rtl/core/life_automaton_row_step.sv
test/testbench.sv
